// ===== hdl/arp_pkg.sv =====
// Shared types and constants for the address-resolution table.
`default_nettype none

package arp_pkg;

    // Fixed field widths of one item and one result.
    localparam int IP_W  = 32;
    localparam int MAC_W = 48;
    localparam int IDX_W = 6;

    // Operation codes carried on func.
    localparam logic FUNC_LOOKUP = 1'b0;
    localparam logic FUNC_LEARN  = 1'b1;

    // Sequencer states, one-hot.
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } state_t;

    // One result item as it leaves the sequencer.
    typedef struct packed {
        logic             done;
        logic             hit;
        logic [MAC_W-1:0] found_mac;
        logic [IDX_W-1:0] entry_index;
        logic             dropped;
    } result_t;

endpackage

`default_nettype wire

// ===== hdl/arp_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none

module arp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== hdl/arp_ctrl.sv =====
// Scan sequencer: walks the filled entries, compares keys and writes back on learn.
`default_nettype none

module arp_ctrl #(
    parameter int TABLE_DEPTH = 64,
    parameter int AW          = 6,
    parameter int CW          = 7
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic                       func,
    input  wire logic [arp_pkg::IP_W-1:0]   ip_address,
    input  wire logic [arp_pkg::MAC_W-1:0]  mac_address,
    output logic                            busy,
    output logic      [AW-1:0]              rd_addr,
    input  wire logic [arp_pkg::IP_W-1:0]   key_rdata,
    input  wire logic [arp_pkg::MAC_W-1:0]  val_rdata,
    output logic                            wr_en,
    output logic      [AW-1:0]              wr_addr,
    output logic      [arp_pkg::IP_W-1:0]   wr_key,
    output logic      [arp_pkg::MAC_W-1:0]  wr_mac,
    output arp_pkg::result_t                result
);

    localparam int PAD_W = AW + arp_pkg::IDX_W;

    arp_pkg::state_t state_reg, state_next;

    logic                       func_reg;
    logic [arp_pkg::IP_W-1:0]   ip_reg;
    logic [arp_pkg::MAC_W-1:0]  mac_reg;
    logic [CW-1:0]              count_reg, count_next;
    logic [CW-1:0]              scan_reg, scan_next;
    logic                       cmp_valid_reg, cmp_valid_next;
    logic [AW-1:0]              cmp_idx_reg, cmp_idx_next;
    arp_pkg::result_t           result_reg, result_next;

    logic accept;
    logic issue;
    logic match;
    logic finish;
    logic full;
    logic learn;
    logic [PAD_W-1:0] cmp_idx_pad;
    logic [PAD_W-1:0] count_pad;

    assign busy    = (state_reg != arp_pkg::ST_IDLE);
    assign accept  = start && !busy;
    assign rd_addr = scan_reg[AW-1:0];
    assign result  = result_reg;

    // Scan control: one read issued per cycle, compared in the cycle after it is issued.
    assign issue  = (state_reg == arp_pkg::ST_SCAN) && (scan_reg < count_reg);
    assign match  = cmp_valid_reg && (key_rdata == ip_reg);
    assign finish = (state_reg == arp_pkg::ST_SCAN) && (match || (!cmp_valid_reg && !issue));
    assign full   = (count_reg >= CW'(TABLE_DEPTH));
    assign learn  = (func_reg == arp_pkg::FUNC_LEARN);

    assign cmp_idx_pad = PAD_W'(cmp_idx_reg);
    assign count_pad   = PAD_W'(count_reg[AW-1:0]);

    // Write-back: update the matching entry, or append at the fill count if the table is not full.
    assign wr_en   = finish && learn && (match || !full);
    assign wr_addr = match ? cmp_idx_reg : count_reg[AW-1:0];
    assign wr_key  = ip_reg;
    assign wr_mac  = mac_reg;

    // Next-state logic.
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        scan_next      = scan_reg;
        cmp_valid_next = 1'b0;
        cmp_idx_next   = cmp_idx_reg;
        result_next    = '0;

        case (state_reg)
            arp_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = arp_pkg::ST_SCAN;
                    scan_next  = '0;
                end
            end
            arp_pkg::ST_SCAN:
            begin
                if (issue)
                begin
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = scan_reg[AW-1:0];
                    scan_next      = scan_reg + CW'(1);
                end
                if (finish)
                begin
                    state_next       = arp_pkg::ST_IDLE;
                    cmp_valid_next   = 1'b0;
                    result_next.done = 1'b1;
                    result_next.hit  = match;
                    if (match)
                    begin
                        result_next.entry_index = cmp_idx_pad[arp_pkg::IDX_W-1:0];
                        if (!learn)
                        begin
                            result_next.found_mac = val_rdata;
                        end
                    end
                    else if (learn)
                    begin
                        if (full)
                        begin
                            result_next.dropped = 1'b1;
                        end
                        else
                        begin
                            result_next.entry_index = count_pad[arp_pkg::IDX_W-1:0];
                            count_next              = count_reg + CW'(1);
                        end
                    end
                end
            end
            default:
            begin
                state_next = arp_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= arp_pkg::ST_IDLE;
            count_reg     <= '0;
            scan_reg      <= '0;
            cmp_valid_reg <= 1'b0;
            result_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            scan_reg      <= scan_next;
            cmp_valid_reg <= cmp_valid_next;
            result_reg    <= result_next;
        end
    end

    // Item payload and compare index.
    always_ff @(posedge clk)
    begin
        cmp_idx_reg <= cmp_idx_next;
        if (accept)
        begin
            func_reg <= func;
            ip_reg   <= ip_address;
            mac_reg  <= mac_address;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/arp_table_learn_lookup_top.sv =====
// Top level of the address-resolution table: key and MAC memories plus scan sequencer.
//
// Usage:
//   An item (func, ip_address, mac_address) is taken at a rising clock edge
//   where start is high and busy is low. func selects lookup or learn.
//   Exactly one result per item appears on hit, found_mac, entry_index and
//   dropped for a single cycle, marked by done; the receiver must take it then.
//   The search reads the filled entries in order, starting at entry 0, and
//   stops at the first matching key or after the last filled entry; on an
//   empty table done follows without any entry read. The key and MAC
//   memories are read one entry per cycle through their single read port.
//   busy stays high during the search, so one item is worked on at a time;
//   a new item may be started in the cycle done is shown.
//   Learn writes back into the memories in the cycle the search ends.
//   Reset empties the table (fill count to zero); memory contents are not
//   cleared and no clearing pass is needed. There is no output back-pressure.
`default_nettype none

module arp_table_learn_lookup_top #(
    parameter int TABLE_DEPTH = 64
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire logic                       func,
    input  wire logic [arp_pkg::IP_W-1:0]   ip_address,
    input  wire logic [arp_pkg::MAC_W-1:0]  mac_address,
    output logic                            done,
    output logic                            hit,
    output logic      [arp_pkg::MAC_W-1:0]  found_mac,
    output logic      [arp_pkg::IDX_W-1:0]  entry_index,
    output logic                            dropped
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    logic [AW-1:0]              rd_addr;
    logic [AW-1:0]              wr_addr;
    logic                       wr_en;
    logic [arp_pkg::IP_W-1:0]   wr_key;
    logic [arp_pkg::MAC_W-1:0]  wr_mac;
    logic [arp_pkg::IP_W-1:0]   key_rdata;
    logic [arp_pkg::MAC_W-1:0]  val_rdata;
    arp_pkg::result_t           result;

    // Address keys.
    arp_ram #(
        .WIDTH (arp_pkg::IP_W),
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_key_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_key),
        .raddr (rd_addr),
        .rdata (key_rdata)
    );

    // MAC values, read in step with the keys.
    arp_ram #(
        .WIDTH (arp_pkg::MAC_W),
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_val_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_mac),
        .raddr (rd_addr),
        .rdata (val_rdata)
    );

    // Search and write-back sequencer.
    arp_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .AW          (AW),
        .CW          (CW)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .func        (func),
        .ip_address  (ip_address),
        .mac_address (mac_address),
        .busy        (busy),
        .rd_addr     (rd_addr),
        .key_rdata   (key_rdata),
        .val_rdata   (val_rdata),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_key      (wr_key),
        .wr_mac      (wr_mac),
        .result      (result)
    );

    // Result ports.
    assign done        = result.done;
    assign hit         = result.hit;
    assign found_mac   = result.found_mac;
    assign entry_index = result.entry_index;
    assign dropped     = result.dropped;

endmodule

`default_nettype wire

// ===== bench/arp_table_learn_lookup_top_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the address-resolution table: it predicts every lookup and learn result.

module arp_table_learn_lookup_top_tb;

    localparam int TABLE_DEPTH = 64;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int RANDOM_ITEMS = 1540;

    // One item waiting to be sent, with an optional drain before it.
    typedef struct {
        logic                      op;
        logic [arp_pkg::IP_W-1:0]  ip;
        logic [arp_pkg::MAC_W-1:0] mac;
        bit                        drain_first;
    } arp_request_t;

    // One predicted result.
    typedef struct packed {
        logic                      hit;
        logic [arp_pkg::MAC_W-1:0] found_mac;
        logic [arp_pkg::IDX_W-1:0] entry_index;
        logic                      dropped;
    } arp_reply_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      start = 1'b0;
    logic                      func = arp_pkg::FUNC_LOOKUP;
    logic [arp_pkg::IP_W-1:0]  ip_address = '0;
    logic [arp_pkg::MAC_W-1:0] mac_address = '0;
    logic                      busy;
    logic                      done;
    logic                      hit;
    logic [arp_pkg::MAC_W-1:0] found_mac;
    logic [arp_pkg::IDX_W-1:0] entry_index;
    logic                      dropped;

    // Predicted copy of the table.
    logic [arp_pkg::IP_W-1:0]  known_ips [TABLE_DEPTH];
    logic [arp_pkg::MAC_W-1:0] known_macs [TABLE_DEPTH];
    int                        table_fill = 0;

    arp_request_t     pending_requests[$];
    arp_reply_t       expected_replies[$];
    int unsigned      items_accepted = 0;
    int unsigned      results_seen = 0;
    int unsigned      mismatch_count = 0;
    int unsigned      cycle_count = 0;
    int               burst_left = 1;
    int               gap_left = 0;

    arp_table_learn_lookup_top #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .func        (func),
        .ip_address  (ip_address),
        .mac_address (mac_address),
        .done        (done),
        .hit         (hit),
        .found_mac   (found_mac),
        .entry_index (entry_index),
        .dropped     (dropped)
    );

    // Clock, 10 ns period.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Counts one mismatch and prints a line for it, for the first 40 only.
    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        mismatch_count++;
        if (mismatch_count <= 40)
            $display("%0t: %s: got %0h, expected %0h", $realtime, what, got, want);
    endtask

    // Searches the predicted table and applies a lookup or a learn to it.
    function automatic arp_reply_t resolve_arp(logic op, logic [arp_pkg::IP_W-1:0] ip,
                                               logic [arp_pkg::MAC_W-1:0] mac);
        arp_reply_t reply;
        int         slot;
        reply = '0;
        slot = -1;
        for (int i = 0; i < table_fill; i++)
        begin
            if (slot < 0 && known_ips[i] == ip)
                slot = i;
        end
        if (slot >= 0)
        begin
            reply.hit = 1'b1;
            reply.entry_index = slot[arp_pkg::IDX_W-1:0];
            if (op == arp_pkg::FUNC_LOOKUP)
                reply.found_mac = known_macs[slot];
            else
                known_macs[slot] = mac;
        end
        else if (op == arp_pkg::FUNC_LEARN)
        begin
            // A new address is appended, unless the table is already full.
            if (table_fill < TABLE_DEPTH)
            begin
                known_ips[table_fill] = ip;
                known_macs[table_fill] = mac;
                reply.entry_index = table_fill[arp_pkg::IDX_W-1:0];
                table_fill++;
            end
            else
            begin
                reply.dropped = 1'b1;
            end
        end
        return reply;
    endfunction

    // Driver: presents pending items in bursts, holding start until busy is low.
    always @(posedge clk)
    begin
        bit           taken;
        bit           hold_off;
        arp_request_t next_req;
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            taken = start && !busy;
            if (taken)
            begin
                expected_replies.push_back(resolve_arp(func, ip_address, mac_address));
                items_accepted <= items_accepted + 1;
            end
            if (!start || taken)
            begin
                hold_off = (gap_left > 0) || (pending_requests.size() == 0);
                // A draining item waits until every earlier item has answered.
                if (!hold_off && pending_requests[0].drain_first)
                    hold_off = taken || (items_accepted != results_seen);
                if (gap_left > 0)
                    gap_left--;
                if (hold_off)
                begin
                    start <= 1'b0;
                end
                else
                begin
                    next_req = pending_requests.pop_front();
                    func <= next_req.op;
                    ip_address <= next_req.ip;
                    mac_address <= next_req.mac;
                    start <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        // Mostly short bursts, now and then a long one with no gap.
                        if ($urandom_range(0, 7) == 0)
                        begin
                            burst_left = $urandom_range(30, 80);
                            gap_left = 0;
                        end
                        else
                        begin
                            burst_left = $urandom_range(1, 10);
                            gap_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 25)
                                                                   : $urandom_range(0, 5);
                        end
                    end
                end
            end
        end
    end

    // Monitor: checks each result against the oldest prediction.
    always @(posedge clk)
    begin
        arp_reply_t want;
        if (rst_n && done)
        begin
            if (items_accepted == results_seen)
            begin
                report_mismatch("result with no item outstanding", 64'(entry_index), 64'd0);
            end
            else
            begin
                want = expected_replies.pop_front();
                results_seen <= results_seen + 1;
                if (hit !== want.hit)
                    report_mismatch("hit", 64'(hit), 64'(want.hit));
                if (found_mac !== want.found_mac)
                    report_mismatch("found_mac", 64'(found_mac), 64'(want.found_mac));
                if (entry_index !== want.entry_index)
                    report_mismatch("entry_index", 64'(entry_index), 64'(want.entry_index));
                if (dropped !== want.dropped)
                    report_mismatch("dropped", 64'(dropped), 64'(want.dropped));
            end
        end
    end

    // Timeout guard.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Adds one item to the pending queue.
    task automatic queue_request(logic op, logic [arp_pkg::IP_W-1:0] ip,
                                 logic [arp_pkg::MAC_W-1:0] mac, bit drain_first);
        arp_request_t req;
        req.op = op;
        req.ip = ip;
        req.mac = mac;
        req.drain_first = drain_first;
        pending_requests.push_back(req);
    endtask

    // Stimulus, reset and end of run.
    initial
    begin
        logic [arp_pkg::IP_W-1:0]  learned_ips[$];
        logic [arp_pkg::IP_W-1:0]  ip;
        logic [arp_pkg::MAC_W-1:0] mac;
        logic [31:0]               rand_hi;
        logic [31:0]               rand_lo;
        logic                      op;
        int                        roll;

        // Directed: miss on the empty table, appends, updates, hits, extremes.
        queue_request(arp_pkg::FUNC_LOOKUP, 32'h0000_0000, 48'h0, 1'b0);
        queue_request(arp_pkg::FUNC_LEARN, 32'h0000_0000, 48'hFFFF_FFFF_FFFF, 1'b0);
        queue_request(arp_pkg::FUNC_LEARN, 32'hFFFF_FFFF, 48'h0, 1'b0);
        queue_request(arp_pkg::FUNC_LOOKUP, 32'h0000_0000, 48'h0, 1'b0);
        queue_request(arp_pkg::FUNC_LOOKUP, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b0);
        queue_request(arp_pkg::FUNC_LEARN, 32'h0000_0000, 48'h1234_5678_9ABC, 1'b0);
        queue_request(arp_pkg::FUNC_LOOKUP, 32'h0000_0000, 48'h0, 1'b0);
        queue_request(arp_pkg::FUNC_LOOKUP, 32'hDEAD_BEEF, 48'hFFFF_FFFF_FFFF, 1'b0);
        queue_request(arp_pkg::FUNC_LEARN, 32'h5555_5555, 48'hAAAA_AAAA_AAAA, 1'b0);
        queue_request(arp_pkg::FUNC_LEARN, 32'hAAAA_AAAA, 48'h5555_5555_5555, 1'b0);
        queue_request(arp_pkg::FUNC_LOOKUP, 32'hAAAA_AAAA, 48'h0, 1'b0);
        queue_request(arp_pkg::FUNC_LEARN, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b0);
        queue_request(arp_pkg::FUNC_LOOKUP, 32'hFFFF_FFFF, 48'h0, 1'b0);
        learned_ips = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA};

        // Random: mostly known addresses, some fresh ones that fill the table
        // and, once it is full, get dropped.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            op = ($urandom_range(0, 1) == 1) ? arp_pkg::FUNC_LEARN : arp_pkg::FUNC_LOOKUP;
            roll = $urandom_range(0, 99);
            rand_hi = $urandom;
            rand_lo = $urandom;
            mac = {rand_hi[15:0], rand_lo};
            if (roll < 72)
            begin
                ip = learned_ips[$urandom_range(0, learned_ips.size() - 1)];
            end
            else
            begin
                ip = $urandom;
                if (op == arp_pkg::FUNC_LEARN && learned_ips.size() < TABLE_DEPTH)
                    learned_ips.push_back(ip);
            end
            queue_request(op, ip, mac, (n == 0) || ($urandom_range(0, 99) == 0));
        end

        // Hold reset, then release it.
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Wait until all items are sent and answered, then let the block settle.
        while (pending_requests.size() != 0 || start || items_accepted != results_seen)
            @(posedge clk);
        repeat (TABLE_DEPTH + 4) @(posedge clk);
        if (expected_replies.size() != 0)
            report_mismatch("items left without a result", 64'(expected_replies.size()), 64'd0);

        if (mismatch_count == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
